// File: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and Kleene helpers for the packed trit set store.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int MAX_TRITS      = 1024;
   localparam int TRITS_PER_WORD = 16;
   localparam int TRIT_W         = 2;
   localparam int WORD_W         = TRITS_PER_WORD * TRIT_W;
   localparam int NUM_WORDS      = (MAX_TRITS + TRITS_PER_WORD - 1) / TRITS_PER_WORD;
   localparam int IDX_W          = $clog2(MAX_TRITS);
   localparam int SLOT_W         = $clog2(TRITS_PER_WORD);
   localparam int WADDR_W        = $clog2(NUM_WORDS);
   localparam int CAP_W          = $clog2(MAX_TRITS + 1);

   localparam logic [TRIT_W-1:0] TRIT_UNKNOWN = 2'd0;
   localparam logic [TRIT_W-1:0] TRIT_FALSE   = 2'd1;
   localparam logic [TRIT_W-1:0] TRIT_TRUE    = 2'd2;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_AND_IN = 3'd2,
      OP_OR_IN  = 3'd3,
      OP_INVERT = 3'd4,
      OP_COUNT  = 3'd5,
      OP_SHRINK = 3'd6,
      OP_TRIM   = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELEM,
      ST_WALK_RD,
      ST_WALK_PROC,
      ST_FINISH
   } state_type;

   // code three is not a trit; it reads as unknown
   function automatic logic [TRIT_W-1:0] norm_trit(input logic [TRIT_W-1:0] t);
      return (t == TRIT_FALSE || t == TRIT_TRUE) ? t : TRIT_UNKNOWN;
   endfunction

   function automatic logic [TRIT_W-1:0] kleene_and(input logic [TRIT_W-1:0] a,
                                                    input logic [TRIT_W-1:0] b);
      if (a == TRIT_FALSE || b == TRIT_FALSE) return TRIT_FALSE;
      if (a == TRIT_TRUE && b == TRIT_TRUE)   return TRIT_TRUE;
      return TRIT_UNKNOWN;
   endfunction

   function automatic logic [TRIT_W-1:0] kleene_or(input logic [TRIT_W-1:0] a,
                                                   input logic [TRIT_W-1:0] b);
      if (a == TRIT_TRUE || b == TRIT_TRUE)   return TRIT_TRUE;
      if (a == TRIT_FALSE && b == TRIT_FALSE) return TRIT_FALSE;
      return TRIT_UNKNOWN;
   endfunction

endpackage

// File: design/packed_trit_set_store.sv
// ----------------------------------------------------------------------------
// packed_trit_set_store
// Growable set of Kleene trits, sixteen to a 32-bit word in a word memory.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  req_    | in        | op, trit_index, trit_value
//  rsp_    | out       | read_trit, match_count, new_capacity, index_error
//
//  Read, write, and_in, or_in and trim do a word read, then modify and
//  write back to the word memory once the rsp_ register is free.
//  Invert and count walk every word below capacity, a read then a process
//  step per word; shrink walks down from the top word and stops at the first word holding a known trit.
//  Reset clears per-word valid bits at once; no clearing pass is needed.
//  req_ready is high in idle; a finished word waits in the rsp_ register
//  and the next word may be accepted meanwhile.
// ----------------------------------------------------------------------------
module packed_trit_set_store
   import pts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_op,
   input  logic [IDX_W-1:0]    req_trit_index,
   input  logic [TRIT_W-1:0]   req_trit_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TRIT_W-1:0]   rsp_read_trit,
   output logic [CAP_W-1:0]    rsp_match_count,
   output logic [CAP_W-1:0]    rsp_new_capacity,
   output logic                rsp_index_error
);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [TRIT_W-1:0]   val_ff, val_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [WADDR_W-1:0]  wcnt_ff, wcnt_in;
   logic [WADDR_W-1:0]  wlast_ff, wlast_in;
   logic [CAP_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_WORDS-1:0] word_valid_ff, word_valid_in;
   logic [WORD_W-1:0]   rd_word_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TRIT_W-1:0]   rsp_trit_ff, rsp_trit_in;
   logic [CAP_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [CAP_W-1:0]    rsp_cap_ff, rsp_cap_in;
   logic                rsp_err_ff, rsp_err_in;

   logic [WORD_W-1:0]   mem [NUM_WORDS];
   logic                mem_we;
   logic [WADDR_W-1:0]  mem_waddr;
   logic [WORD_W-1:0]   mem_wdata;
   logic                rd_en;
   logic [WADDR_W-1:0]  rd_addr;

   logic                accept, out_free;
   logic [WADDR_W:0]    nwords;
   logic [SLOT_W-1:0]   slot;
   logic                in_cap, idx_err;
   logic [TRIT_W-1:0]   old_trit, res_trit, cur_trit;
   logic [TRITS_PER_WORD-1:0] match_vec, known_vec;
   logic [SLOT_W-1:0]   top_slot;
   logic                last_part;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign nwords    = cap_ff[CAP_W-1:SLOT_W] + {{WADDR_W{1'b0}}, |cap_ff[SLOT_W-1:0]};

   assign slot     = idx_ff[SLOT_W-1:0];
   assign in_cap   = {1'b0, idx_ff} < cap_ff;
   assign idx_err  = {1'b0, idx_ff} >= CAP_W'(MAX_TRITS);
   assign old_trit = in_cap ? norm_trit(rd_word_ff[{slot, 1'b0} +: TRIT_W]) : TRIT_UNKNOWN;
   assign last_part = (wcnt_ff == wlast_ff) && (cap_ff[SLOT_W-1:0] != '0);

   // per-trit views of the word under walk
   always_comb begin
      match_vec = '0;
      known_vec = '0;
      top_slot  = '0;
      for (int k = 0; k < TRITS_PER_WORD; k++) begin
         cur_trit = norm_trit(rd_word_ff[k*TRIT_W +: TRIT_W]);
         match_vec[k] = (cur_trit == val_ff) &&
                        (!last_part || SLOT_W'(k) < cap_ff[SLOT_W-1:0]);
         known_vec[k] = (cur_trit != TRIT_UNKNOWN);
         if (known_vec[k]) top_slot = SLOT_W'(k);
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      cap_in        = cap_ff;
      wcnt_in       = wcnt_ff;
      wlast_in      = wlast_ff;
      cnt_in        = cnt_ff;
      word_valid_in = word_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_trit_in   = rsp_trit_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_cap_in    = rsp_cap_ff;
      rsp_err_in    = rsp_err_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[IDX_W-1:SLOT_W];
      mem_wdata     = rd_word_ff;
      rd_en         = 1'b0;
      rd_addr       = req_trit_index[IDX_W-1:SLOT_W];
      res_trit      = TRIT_UNKNOWN;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = op_type'(req_op);
               idx_in = req_trit_index;
               val_in = norm_trit(req_trit_value);
               cnt_in = '0;
               wlast_in = WADDR_W'(nwords - 1'b1);
               case (op_type'(req_op))
                  OP_INVERT, OP_COUNT, OP_SHRINK: begin
                     wcnt_in  = (op_type'(req_op) == OP_SHRINK) ?
                                WADDR_W'(nwords - 1'b1) : '0;
                     state_in = (nwords == '0) ? ST_FINISH : ST_WALK_RD;
                  end
                  default: begin
                     rd_en    = 1'b1;
                     state_in = ST_ELEM;
                  end
               endcase
            end
         end

         ST_ELEM: begin
            if (out_free) begin
               unique case (op_ff)
                  OP_WRITE:  res_trit = val_ff;
                  OP_AND_IN: res_trit = kleene_and(old_trit, val_ff);
                  OP_OR_IN:  res_trit = kleene_or(old_trit, val_ff);
                  OP_READ:   res_trit = old_trit;
                  default:   res_trit = TRIT_UNKNOWN;
               endcase
               if (!idx_err) begin
                  case (op_ff)
                     OP_WRITE, OP_AND_IN, OP_OR_IN: begin
                        if (in_cap || res_trit != TRIT_UNKNOWN) begin
                           mem_we = 1'b1;
                           for (int k = 0; k < TRITS_PER_WORD; k++)
                              if (SLOT_W'(k) == slot)
                                 mem_wdata[k*TRIT_W +: TRIT_W] = res_trit;
                           word_valid_in[idx_ff[IDX_W-1:SLOT_W]] = 1'b1;
                           if (!in_cap) cap_in = CAP_W'(idx_ff) + 1'b1;
                        end
                     end
                     OP_TRIM: begin
                        // clear everything past the kept index
                        if (in_cap) begin
                           cap_in = CAP_W'(idx_ff) + 1'b1;
                           mem_we = 1'b1;
                           for (int k = 0; k < TRITS_PER_WORD; k++)
                              if (SLOT_W'(k) > slot)
                                 mem_wdata[k*TRIT_W +: TRIT_W] = TRIT_UNKNOWN;
                           for (int w = 0; w < NUM_WORDS; w++)
                              if (WADDR_W'(w) > idx_ff[IDX_W-1:SLOT_W])
                                 word_valid_in[w] = 1'b0;
                           word_valid_in[idx_ff[IDX_W-1:SLOT_W]] = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
               rsp_valid_in = 1'b1;
               rsp_trit_in  = idx_err ? TRIT_UNKNOWN : res_trit;
               rsp_count_in = '0;
               rsp_cap_in   = cap_in;
               rsp_err_in   = idx_err;
               state_in     = ST_IDLE;
            end
         end

         ST_WALK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = wcnt_ff;
            state_in = ST_WALK_PROC;
         end

         ST_WALK_PROC: begin
            state_in = ST_WALK_RD;
            case (op_ff)
               OP_INVERT: begin
                  // swapping the two bits turns false into true and back
                  mem_we    = 1'b1;
                  mem_waddr = wcnt_ff;
                  for (int k = 0; k < TRITS_PER_WORD; k++)
                     mem_wdata[k*TRIT_W +: TRIT_W] = {rd_word_ff[k*TRIT_W],
                                                      rd_word_ff[k*TRIT_W + 1]};
                  word_valid_in[wcnt_ff] = 1'b1;
               end
               OP_COUNT: begin
                  cnt_in = cnt_ff + CAP_W'($countones(match_vec));
               end
               default: ;
            endcase
            if (op_ff == OP_SHRINK) begin
               // trits above the last known one are already unknown
               if (|known_vec) begin
                  cap_in   = {1'b0, wcnt_ff, top_slot} + 1'b1;
                  state_in = ST_FINISH;
               end else if (wcnt_ff == '0) begin
                  cap_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  wcnt_in = wcnt_ff - 1'b1;
               end
            end else if (wcnt_ff == wlast_ff) begin
               state_in = ST_FINISH;
            end else begin
               wcnt_in = wcnt_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_trit_in  = TRIT_UNKNOWN;
               rsp_count_in = (op_ff == OP_COUNT) ? cnt_ff : '0;
               rsp_cap_in   = cap_ff;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= '0;
         word_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      wcnt_ff      <= wcnt_in;
      wlast_ff     <= wlast_in;
      cnt_ff       <= cnt_in;
      rsp_trit_ff  <= rsp_trit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_cap_ff   <= rsp_cap_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // word memory; a word never written since reset or trim reads as unknown
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_word_ff <= word_valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_trit    = rsp_trit_ff;
   assign rsp_match_count  = rsp_count_ff;
   assign rsp_new_capacity = rsp_cap_ff;
   assign rsp_index_error  = rsp_err_ff;

   a_cap_range: assert property (@(posedge clock) disable iff (reset)
      cap_ff <= CAP_W'(MAX_TRITS))
      else $error("capacity beyond store");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_ELEM || state_ff == ST_WALK_PROC))
      else $error("word write outside modify step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff <= rsp_cap_ff)
      else $error("count exceeds capacity");

   a_elem_path: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_READ || req_op == OP_WRITE || req_op == OP_AND_IN ||
                  req_op == OP_OR_IN || req_op == OP_TRIM)) |=> state_ff == ST_ELEM)
      else $error("element op did not go to modify step");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_RD) |-> wcnt_ff <= wlast_ff)
      else $error("walk past last word");

endmodule
